// ===== sv/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
// hsv2rgb_pkg: widths, fixed-point constants, hue sectors and helper functions
// for the hsv to rgb converter; depends on nothing

package hsv2rgb_pkg;

   // fixed-point format of hue, saturation and brightness
   localparam int FRAC_BITS    = 16;
   localparam int CHANNEL_BITS = 8;

   // unsigned q.FRAC_BITS value that can hold exactly 1.0
   localparam int Q_WIDTH     = FRAC_BITS + 1;
   // hue times six: three sector bits above the fraction
   localparam int HUE6_WIDTH  = FRAC_BITS + 3;
   localparam int SECT_WIDTH  = 3;
   // full product of two q values
   localparam int PROD_WIDTH  = 2 * Q_WIDTH;
   // product times the channel maximum
   localparam int SCALE_WIDTH = PROD_WIDTH + CHANNEL_BITS;
   localparam int PACK_WIDTH  = 3 * CHANNEL_BITS;

   localparam logic [Q_WIDTH-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   // hue sectors, one sixth of a turn each
   typedef enum logic [SECT_WIDTH-1:0] {
      SECT_RED_YELLOW    = 3'd0,
      SECT_YELLOW_GREEN  = 3'd1,
      SECT_GREEN_CYAN    = 3'd2,
      SECT_CYAN_BLUE     = 3'd3,
      SECT_BLUE_MAGENTA  = 3'd4,
      SECT_MAGENTA_RED   = 3'd5
   } sector_type;

   // anything above 1.0 counts as 1.0
   function automatic logic [Q_WIDTH-1:0] clamp_one(input logic [Q_WIDTH-1:0] x);
      return (x > ONE_Q) ? ONE_Q : x;
   endfunction

   // floor(p * (2^CHANNEL_BITS - 1) / 2^(2*FRAC_BITS)) by shift and subtract
   function automatic logic [CHANNEL_BITS-1:0] chan_scale(
      input logic [PROD_WIDTH-1:0] p);
      logic [SCALE_WIDTH-1:0] w;
      w = {p, {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, p};
      return w[2*FRAC_BITS +: CHANNEL_BITS];
   endfunction

endpackage

// ===== sv/hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// hsv_to_rgb_converter: five-stage pipelined hsv to 8-bit rgb conversion
// depends on hsv2rgb_pkg for widths, sector codes and scaling functions
//
// usage
//   request channel: req_hue (fraction of a turn), req_saturation and
//   req_brightness (q16, 65536 is 1.0, larger values clamp to 1.0); a
//   request is taken on a clock edge with req_valid high and req_stall low
//   response channel: rsp_red, rsp_green, rsp_blue and rsp_packed_color
//   (red in 23:16, green 15:8, blue 7:0), taken with rsp_valid high and
//   rsp_stall low
//   pipeline: a request passes stages 1 to 5, the last the output register;
//   one request per cycle is sustained while rsp_stall is low, each of the
//   five stages holds one item; two rounds of 17x17 multipliers set the depth
//   stall: rsp_stall freezes the output register; upstream stages keep
//   filling their empty slots, and req_stall rises only once every stage
//   ahead of the input holds an item; nothing is lost or repeated
//   reset: synchronous, clears all stage valid bits; no other state

module hsv_to_rgb_converter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [hsv2rgb_pkg::FRAC_BITS-1:0]      req_hue,
   input  logic [hsv2rgb_pkg::Q_WIDTH-1:0]        req_saturation,
   input  logic [hsv2rgb_pkg::Q_WIDTH-1:0]        req_brightness,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_red,
   output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_green,
   output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_blue,
   output logic [hsv2rgb_pkg::PACK_WIDTH-1:0]     rsp_packed_color
);

   localparam int F = hsv2rgb_pkg::FRAC_BITS;
   localparam int Q = hsv2rgb_pkg::Q_WIDTH;
   localparam int P = hsv2rgb_pkg::PROD_WIDTH;
   localparam int C = hsv2rgb_pkg::CHANNEL_BITS;
   localparam int H = hsv2rgb_pkg::HUE6_WIDTH;

   // stage valid bits and slot-free flags
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage 1: clamp, sector and fraction
   logic [H-1:0]                 hue6;
   logic [Q-1:0]                 sat1_ff, sat1_in, val1_ff, val1_in;
   logic [F-1:0]                 frac1_ff, frac1_in;
   logic [Q-1:0]                 ofr1_ff, ofr1_in;
   hsv2rgb_pkg::sector_type      sec1_ff, sec1_in;

   // stage 2: saturation products
   logic [Q-1:0]                 sat2_ff, val2_ff;
   hsv2rgb_pkg::sector_type      sec2_ff;
   logic [Q+F-1:0]               sf2_ff, sf2_in;
   logic [P-1:0]                 sfc2_ff, sfc2_in;

   // stage 3: channel factors
   logic [Q-1:0]                 val3_ff;
   hsv2rgb_pkg::sector_type      sec3_ff;
   logic [Q-1:0]                 ta3_ff, ta3_in, tb3_ff, tb3_in, tc3_ff, tc3_in;

   // stage 4: brightness products
   hsv2rgb_pkg::sector_type      sec4_ff;
   logic [P-1:0]                 pv4_ff, pv4_in, pa4_ff, pa4_in;
   logic [P-1:0]                 pb4_ff, pb4_in, pc4_ff, pc4_in;

   // stage 5: output register
   logic [C-1:0]                 cv, ca, cb, cc;
   logic [C-1:0]                 red_ff, red_in, green_ff, green_in;
   logic [C-1:0]                 blue_ff, blue_in;

   // a stage may load when it is empty or its item moves on
   assign rdy5      = !rsp_valid_ff || !rsp_stall;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) rsp_valid_ff <= v4_ff;
      end
   end

   // stage 1 logic: hue times six as two shifted adds
   always_comb begin
      hue6     = {1'b0, req_hue, 2'b00} + {2'b00, req_hue, 1'b0};
      sec1_in  = hsv2rgb_pkg::sector_type'(hue6[H-1 -: hsv2rgb_pkg::SECT_WIDTH]);
      frac1_in = hue6[F-1:0];
      ofr1_in  = hsv2rgb_pkg::ONE_Q - {1'b0, hue6[F-1:0]};
      sat1_in  = hsv2rgb_pkg::clamp_one(req_saturation);
      val1_in  = hsv2rgb_pkg::clamp_one(req_brightness);
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         sec1_ff  <= sec1_in;
         frac1_ff <= frac1_in;
         ofr1_ff  <= ofr1_in;
         sat1_ff  <= sat1_in;
         val1_ff  <= val1_in;
      end
   end

   // stage 2 logic: s*f and s*(1-f)
   always_comb begin
      sf2_in  = {{F{1'b0}}, sat1_ff} * {{Q{1'b0}}, frac1_ff};
      sfc2_in = {{Q{1'b0}}, sat1_ff} * {{Q{1'b0}}, ofr1_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         sf2_ff  <= sf2_in;
         sfc2_ff <= sfc2_in;
         sat2_ff <= sat1_ff;
         val2_ff <= val1_ff;
         sec2_ff <= sec1_ff;
      end
   end

   // stage 3 logic: truncate the products and form the factors
   always_comb begin
      ta3_in = hsv2rgb_pkg::ONE_Q - sat2_ff;
      tb3_in = hsv2rgb_pkg::ONE_Q - sf2_ff[F +: Q];
      tc3_in = hsv2rgb_pkg::ONE_Q - sfc2_ff[F +: Q];
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         ta3_ff  <= ta3_in;
         tb3_ff  <= tb3_in;
         tc3_ff  <= tc3_in;
         val3_ff <= val2_ff;
         sec3_ff <= sec2_ff;
      end
   end

   // stage 4 logic: brightness times each factor, full factor is a shift
   always_comb begin
      pv4_in = {{(P-Q-F){1'b0}}, val3_ff, {F{1'b0}}};
      pa4_in = {{Q{1'b0}}, val3_ff} * {{Q{1'b0}}, ta3_ff};
      pb4_in = {{Q{1'b0}}, val3_ff} * {{Q{1'b0}}, tb3_ff};
      pc4_in = {{Q{1'b0}}, val3_ff} * {{Q{1'b0}}, tc3_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         pv4_ff  <= pv4_in;
         pa4_ff  <= pa4_in;
         pb4_ff  <= pb4_in;
         pc4_ff  <= pc4_in;
         sec4_ff <= sec3_ff;
      end
   end

   // stage 5 logic: scale to channel range and permute by sector
   always_comb begin
      cv = hsv2rgb_pkg::chan_scale(pv4_ff);
      ca = hsv2rgb_pkg::chan_scale(pa4_ff);
      cb = hsv2rgb_pkg::chan_scale(pb4_ff);
      cc = hsv2rgb_pkg::chan_scale(pc4_ff);
      case (sec4_ff)
         hsv2rgb_pkg::SECT_RED_YELLOW: begin
            red_in = cv; green_in = cc; blue_in = ca;
         end
         hsv2rgb_pkg::SECT_YELLOW_GREEN: begin
            red_in = cb; green_in = cv; blue_in = ca;
         end
         hsv2rgb_pkg::SECT_GREEN_CYAN: begin
            red_in = ca; green_in = cv; blue_in = cc;
         end
         hsv2rgb_pkg::SECT_CYAN_BLUE: begin
            red_in = ca; green_in = cb; blue_in = cv;
         end
         hsv2rgb_pkg::SECT_BLUE_MAGENTA: begin
            red_in = cc; green_in = ca; blue_in = cv;
         end
         default: begin
            red_in = cv; green_in = ca; blue_in = cb;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   // response ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_packed_color = {red_ff, green_ff, blue_ff};

   // a full pipeline held at the output must push back on requests
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && v1_ff && v2_ff && v3_ff && v4_ff) |-> req_stall)
      else $error("full stalled pipeline does not back-pressure requests");

   // an item in the last stage reaches the output when the output frees up
   assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rdy5) |=> rsp_valid_ff)
      else $error("item lost between last stage and output");

   // an accepted request always lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted request not captured");

   // an idle output with an empty pipeline stays idle
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !v4_ff) |=> !rsp_valid_ff)
      else $error("response raised with no item in flight");

endmodule

// ===== tb/rgb_result_checker.sv =====
`timescale 1ns / 1ps
// rgb_result_checker: watches the request and response channels of the hsv to
// rgb converter, predicts each colour and compares it; depends on hsv2rgb_pkg

module rgb_result_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [hsv2rgb_pkg::FRAC_BITS-1:0]      req_hue,
   input  logic [hsv2rgb_pkg::Q_WIDTH-1:0]        req_saturation,
   input  logic [hsv2rgb_pkg::Q_WIDTH-1:0]        req_brightness,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_red,
   input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_green,
   input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_blue,
   input  logic [hsv2rgb_pkg::PACK_WIDTH-1:0]     rsp_packed_color,
   output int                                     mismatch_count,
   output int                                     colours_in_flight
);

   typedef struct packed {
      logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] red;
      logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] green;
      logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] blue;
      logic [hsv2rgb_pkg::PACK_WIDTH-1:0]   packed_rgb;
   } rgb_colour_type;

   localparam logic [63:0] UNITY    = 64'd1 << hsv2rgb_pkg::FRAC_BITS;
   localparam logic [63:0] CHAN_TOP = (64'd1 << hsv2rgb_pkg::CHANNEL_BITS) - 64'd1;

   rgb_colour_type predicted_colours[$];

   // brightness times a factor, scaled to the channel range and truncated
   function automatic logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] to_channel(
      input logic [63:0] v,
      input logic [63:0] t);
      logic [63:0] w;
      w = (v * t * CHAN_TOP) >> (2 * hsv2rgb_pkg::FRAC_BITS);
      return w[hsv2rgb_pkg::CHANNEL_BITS-1:0];
   endfunction

   function automatic rgb_colour_type hsv_to_rgb_colour(
      input logic [hsv2rgb_pkg::FRAC_BITS-1:0] hue,
      input logic [hsv2rgb_pkg::Q_WIDTH-1:0]   sat,
      input logic [hsv2rgb_pkg::Q_WIDTH-1:0]   bri);
      logic [63:0] s, v, h6, f, ta, tb, tc;
      logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] cv, ca, cb, cc;
      hsv2rgb_pkg::sector_type sect;
      rgb_colour_type c;
      // anything beyond 1.0 is taken as 1.0
      s = (64'(sat) > UNITY) ? UNITY : 64'(sat);
      v = (64'(bri) > UNITY) ? UNITY : 64'(bri);
      h6 = 64'(hue) * 64'd6;
      sect = hsv2rgb_pkg::sector_type'(
                h6[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::SECT_WIDTH]);
      f = h6 & (UNITY - 64'd1);
      ta = UNITY - s;
      tb = UNITY - ((s * f) >> hsv2rgb_pkg::FRAC_BITS);
      tc = UNITY - ((s * (UNITY - f)) >> hsv2rgb_pkg::FRAC_BITS);
      cv = to_channel(v, UNITY);
      ca = to_channel(v, ta);
      cb = to_channel(v, tb);
      cc = to_channel(v, tc);
      // per-sector permutation, the last sector also covers anything else
      case (sect)
         hsv2rgb_pkg::SECT_RED_YELLOW: begin
            c.red = cv; c.green = cc; c.blue = ca;
         end
         hsv2rgb_pkg::SECT_YELLOW_GREEN: begin
            c.red = cb; c.green = cv; c.blue = ca;
         end
         hsv2rgb_pkg::SECT_GREEN_CYAN: begin
            c.red = ca; c.green = cv; c.blue = cc;
         end
         hsv2rgb_pkg::SECT_CYAN_BLUE: begin
            c.red = ca; c.green = cb; c.blue = cv;
         end
         hsv2rgb_pkg::SECT_BLUE_MAGENTA: begin
            c.red = cc; c.green = ca; c.blue = cv;
         end
         default: begin
            c.red = cv; c.green = ca; c.blue = cb;
         end
      endcase
      c.packed_rgb = {c.red, c.green, c.blue};
      return c;
   endfunction

   // queue a prediction per accepted request, check each accepted response
   always @(posedge clock) begin
      rgb_colour_type want;
      if (reset) begin
         mismatch_count    <= 0;
         colours_in_flight <= 0;
      end else begin
         if (req_valid && !req_stall)
            predicted_colours.push_back(hsv_to_rgb_colour(req_hue, req_saturation,
                                                          req_brightness));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_colours.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               $display("%0t: response with nothing outstanding: %h", $time,
                        rsp_packed_color);
            end else begin
               want = predicted_colours.pop_front();
               if (rsp_red !== want.red || rsp_green !== want.green ||
                   rsp_blue !== want.blue || rsp_packed_color !== want.packed_rgb) begin
                  mismatch_count <= mismatch_count + 1;
                  $display("%0t: colour mismatch expected r %h g %h b %h packed %h",
                           $time, want.red, want.green, want.blue, want.packed_rgb);
                  $display("%0t:                   actual r %h g %h b %h packed %h",
                           $time, rsp_red, rsp_green, rsp_blue, rsp_packed_color);
               end
            end
         end
         colours_in_flight <= predicted_colours.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: drives directed and random hsv colours into hsv_to_rgb_converter with
// random gaps and stalls; depends on hsv2rgb_pkg and rgb_result_checker

module tb_top;

   localparam int RANDOM_COLOURS = 1400;
   localparam int HOLD_A = 400;
   localparam int HOLD_B = 1200;
   localparam int HOLD_LEN = 80;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic [hsv2rgb_pkg::FRAC_BITS-1:0]      req_hue = '0;
   logic [hsv2rgb_pkg::Q_WIDTH-1:0]        req_saturation = '0;
   logic [hsv2rgb_pkg::Q_WIDTH-1:0]        req_brightness = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_red;
   logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_green;
   logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   rsp_blue;
   logic [hsv2rgb_pkg::PACK_WIDTH-1:0]     rsp_packed_color;
   int                                     mismatch_count;
   int                                     colours_in_flight;
   bit                                     sender_quiet = 1'b0;

   always #5 clock = ~clock;

   hsv_to_rgb_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hue          (req_hue),
      .req_saturation   (req_saturation),
      .req_brightness   (req_brightness),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_packed_color (rsp_packed_color)
   );

   rgb_result_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_hue           (req_hue),
      .req_saturation    (req_saturation),
      .req_brightness    (req_brightness),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_packed_color  (rsp_packed_color),
      .mismatch_count    (mismatch_count),
      .colours_in_flight (colours_in_flight)
   );

   // offer one request, with an occasional gap first, and wait until it is taken
   task automatic send_colour(input logic [hsv2rgb_pkg::FRAC_BITS-1:0] h,
                              input logic [hsv2rgb_pkg::Q_WIDTH-1:0] s,
                              input logic [hsv2rgb_pkg::Q_WIDTH-1:0] v);
      while (!sender_quiet && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= h;
      req_saturation <= s;
      req_brightness <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly in range, sometimes beyond 1.0, sometimes exactly at the ends
   function automatic logic [hsv2rgb_pkg::Q_WIDTH-1:0] random_q();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         return hsv2rgb_pkg::Q_WIDTH'($urandom_range(0, 32'(hsv2rgb_pkg::ONE_Q)));
      else if (pick < 90)
         return hsv2rgb_pkg::Q_WIDTH'($urandom);
      else
         return (pick < 95) ? hsv2rgb_pkg::ONE_Q : '0;
   endfunction

   // receiver: random stalls, a quiet stretch, and two long hold-offs
   initial begin
      int cyc;
      cyc = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         cyc++;
         if ((cyc >= HOLD_A && cyc < HOLD_A + HOLD_LEN) ||
             (cyc >= HOLD_B && cyc < HOLD_B + HOLD_LEN))
            rsp_stall <= 1'b1;
         else if (cyc >= 700 && cyc < 1000)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(99) < 19);
         @(posedge clock);
      end
   end

   // run limit
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int n;
      logic [hsv2rgb_pkg::FRAC_BITS-1:0] h;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: hue ends and sector edges, saturation and brightness extremes
      send_colour(16'd0, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'hffff, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd10922, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd10923, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd21845, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd21846, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd32768, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd43690, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd43691, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd54613, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd54614, hsv2rgb_pkg::ONE_Q, hsv2rgb_pkg::ONE_Q);
      // each sector at mid-point, part saturation
      for (int k = 0; k < 6; k++)
         send_colour(16'(k * 10923 + 5461), 17'd40000, 17'd50000);
      // saturation zero, brightness zero and full
      send_colour(16'd12345, '0, hsv2rgb_pkg::ONE_Q);
      send_colour(16'd12345, hsv2rgb_pkg::ONE_Q, '0);
      send_colour(16'hffff, 17'd65535, 17'd65535);
      // saturation and brightness beyond 1.0
      send_colour(16'd30000, 17'd65537, 17'd1);
      send_colour(16'd30000, 17'h1ffff, 17'h1ffff);
      send_colour(16'd50000, 17'd1, 17'd65537);
      send_colour(16'haaaa, 17'h15555, 17'h0aaaa);

      // random colours, with a stretch where the sender never idles
      for (int i = 0; i < RANDOM_COLOURS; i++) begin
         sender_quiet = (i >= 600 && i < 800);
         h = ($urandom_range(9) == 0) ? 16'(($urandom_range(5) * 65536 + 5) / 6) :
                                        16'($urandom);
         send_colour(h, random_q(), random_q());
      end
      req_valid <= 1'b0;

      // drain outstanding colours, then let the bench settle before the verdict
      for (n = 0; n < 5000 && colours_in_flight != 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && colours_in_flight == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
